// ----- src/grc_pkg.sv -----
package grc_pkg;

    localparam int XW           = 34;
    localparam int CW           = 12;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_X0    = 652032874;
    localparam int DIR_EPS      = 1074;
    localparam int DIST_MAX     = 131071;
    localparam int REG_PX       = 0;
    localparam int REG_PY       = 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CORDIC,
        S_SETUP,
        S_DD,
        S_MUL,
        S_DIVD,
        S_DIVC,
        S_PICK,
        S_READ,
        S_DONE
    } t_state;

    function automatic logic [29:0] atan_unit(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/grid_ray_wall_caster_unit.sv -----
// Grid ray caster over a wall bitmap of MAP_W x MAP_H cells.
// Input channel: a beat is taken when start is high and busy is low.
//   func 0 writes one map cell in that cycle; busy stays low, no result.
//   func 1 casts a ray from the player position at ray_angle.
// Result channel: o_done pulses one cycle with distance, side, texture
//   coordinate and status; the receiver cannot hold it off.
// Config: i_cfg_we writes player_x (index 0) or player_y (index 1) at once.
// Steps of a cast: CORDIC rotation (skipped for axis angles) and a setup
//   state, then per tested grid line the one-bit-a-cycle restoring divider
//   computes the distance and the crossing coordinate of the line just
//   advanced (NUM_W = 56 quotient bits at default sizes); the first line
//   also does this for the other axis when both axes are live.
//   A cast strobes o_done once it ends; busy drops the cycle after.
// Reset: a clearing pass writes every map cell empty, one cell a cycle,
//   with busy high; config writes are taken meanwhile.
// Leaving the map or running out of steps gives status 1.
module grid_ray_wall_caster_unit #(
    parameter int MAP_W     = 64,
    parameter int MAP_H     = 64,
    parameter int FRAC_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_ray_angle,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_cell_wall,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic [16:0] o_hit_distance,
    output logic [1:0]  o_wall_side,
    output logic [9:0]  o_tex_coord,
    output logic        o_status
);

    localparam int XW     = grc_pkg::XW;
    localparam int CW     = grc_pkg::CW;
    localparam int DDW    = CW + FRAC_BITS + 1;
    localparam int PW     = DDW + XW;
    localparam int NUM_W  = PW - 1;
    localparam int VW     = NUM_W + 2;
    localparam int DVW    = XW - 1;
    localparam int DEPTH  = MAP_W * MAP_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int RB     = $clog2(MAP_H);
    localparam int CB     = $clog2(MAP_W);
    localparam int LIMIT  = MAP_W + MAP_H + 4;
    localparam int NW     = $clog2(LIMIT + 1);
    localparam int DCW    = $clog2(NUM_W + 1);
    localparam int TEX_DN = (FRAC_BITS >= 10) ? (FRAC_BITS - 10) : 0;
    localparam int TEX_UP = (FRAC_BITS < 10) ? (10 - FRAC_BITS) : 0;

    grc_pkg::t_state r_state, n_state;

    logic [15:0]           r_px, r_py;
    logic [AW-1:0]         r_clr;
    logic [1:0]            r_quad;
    logic [4:0]            r_i;
    logic signed [XW-1:0]  r_cx, r_cy, r_cz;
    logic signed [XW-1:0]  r_dx, r_dy;
    logic                  r_sxn, r_syn;
    logic signed [CW-1:0]  r_vx, r_hy;
    logic                  r_ax, r_both;
    logic signed [DDW-1:0] r_dd;
    logic signed [PW-1:0]  r_prod;
    logic [NUM_W-1:0]      r_nq;
    logic [DVW-1:0]        r_rem, r_div;
    logic [DCW-1:0]        r_cnt;
    logic [NUM_W-1:0]      r_vd, r_hd;
    logic signed [VW-1:0]  r_vy, r_hx;
    logic [NW-1:0]         r_n;
    logic                  r_vert;
    logic [16:0]           r_cand_dist;
    logic [9:0]            r_cand_tex;
    logic [1:0]            r_cand_side;
    logic [16:0]           r_res_dist;
    logic [1:0]            r_res_side;
    logic [9:0]            r_res_tex;
    logic                  r_res_status;

    logic                  accept, load_ok, ram_we, ram_wd, ram_rd;
    logic [AW-1:0]         ram_addr, load_addr, pick_addr;

    // CORDIC step
    logic signed [XW-1:0]  xs, ys, atan_v;
    assign xs     = r_cx >>> r_i;
    assign ys     = r_cy >>> r_i;
    assign atan_v = XW'(grc_pkg::atan_unit(r_i));

    // quadrant mapping
    logic signed [XW-1:0]  cs, sn, dx0, dy0;
    logic [DVW-1:0]        dx0_mag, dy0_mag;
    always_comb begin
        unique case (r_quad)
            2'd0: begin cs = r_cx;  sn = r_cy;  end
            2'd1: begin cs = -r_cy; sn = r_cx;  end
            2'd2: begin cs = -r_cx; sn = -r_cy; end
            default: begin cs = r_cy; sn = -r_cx; end
        endcase
        dx0     = cs;
        dy0     = -sn;
        dx0_mag = dx0[XW-1] ? DVW'(-dx0) : DVW'(dx0);
        dy0_mag = dy0[XW-1] ? DVW'(-dy0) : DVW'(dy0);
    end

    logic                  sxn0, syn0;
    assign sxn0 = dx0_mag >= DVW'(grc_pkg::DIR_EPS);
    assign syn0 = dy0_mag >= DVW'(grc_pkg::DIR_EPS);

    logic [DVW-1:0]        dx_mag, dy_mag;
    assign dx_mag = r_dx[XW-1] ? DVW'(-r_dx) : DVW'(r_dx);
    assign dy_mag = r_dy[XW-1] ? DVW'(-r_dy) : DVW'(r_dy);

    // offset to the next line of the current axis
    logic signed [DDW-1:0] dd_n;
    logic [DDW-1:0]        dd_mag;
    logic [NUM_W-1:0]      prod_mag;
    assign dd_n = r_ax ? ((DDW'(r_hy) <<< FRAC_BITS) - DDW'(r_py))
                       : ((DDW'(r_vx) <<< FRAC_BITS) - DDW'(r_px));
    assign dd_mag   = r_dd[DDW-1] ? DDW'(-r_dd) : DDW'(r_dd);
    assign prod_mag = r_prod[PW-1] ? NUM_W'(-r_prod) : NUM_W'(r_prod);

    // restoring divider, one quotient bit a cycle
    logic [DVW:0]          rem_t, rem_s;
    logic                  q_bit, div_last;
    logic [NUM_W-1:0]      nq_n;
    logic [DVW-1:0]        rem_n;
    always_comb begin
        rem_t = {r_rem, r_nq[NUM_W-1]};
        q_bit = rem_t >= {1'b0, r_div};
        rem_s = q_bit ? (rem_t - {1'b0, r_div}) : rem_t;
        rem_n = rem_s[DVW-1:0];
        nq_n  = {r_nq[NUM_W-2:0], q_bit};
    end
    assign div_last = r_cnt == DCW'(NUM_W - 1);

    logic                  cneg;
    logic signed [VW-1:0]  qs, coord;
    always_comb begin
        cneg  = r_prod[PW-1] ^ (r_ax ? r_dy[XW-1] : r_dx[XW-1]);
        qs    = $signed({2'b00, nq_n});
        coord = (r_ax ? VW'(r_px) : VW'(r_py)) + (cneg ? -qs : qs);
    end

    // line choice and cell address
    logic                  vert, inv, off;
    logic signed [VW-1:0]  row, col;
    logic [FRAC_BITS-1:0]  frac, w;
    logic [NUM_W-1:0]      dsel;
    logic [9:0]            tex;
    always_comb begin
        vert = r_sxn && (!r_syn || (r_vd < r_hd));
        if (vert) begin
            row  = r_vy >>> FRAC_BITS;
            col  = VW'(r_vx) - (r_dx[XW-1] ? VW'(1) : VW'(0));
            frac = r_vy[FRAC_BITS-1:0];
            inv  = !r_dx[XW-1];
            dsel = r_vd;
        end else begin
            row  = VW'(r_hy) - (r_dy[XW-1] ? VW'(1) : VW'(0));
            col  = r_hx >>> FRAC_BITS;
            frac = r_hx[FRAC_BITS-1:0];
            inv  = r_dy[XW-1];
            dsel = r_hd;
        end
        off = row[VW-1] || (row >= VW'(MAP_H)) || col[VW-1] || (col >= VW'(MAP_W));
        w   = inv ? ((frac == '0) ? '1 : (~frac + 1'b1)) : frac;
        tex = 10'((32'(w) << TEX_UP) >> TEX_DN);
    end
    assign pick_addr = AW'(row[RB-1:0]) * AW'(MAP_W) + AW'(col[CB-1:0]);

    assign accept    = start && !busy;
    assign load_ok   = (32'(i_cell_row) < MAP_H) && (32'(i_cell_col) < MAP_W);
    assign load_addr = AW'(32'(i_cell_row) * MAP_W + 32'(i_cell_col));

    always_comb begin
        if (r_state == grc_pkg::S_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
            ram_wd   = 1'b0;
        end else if (accept && !i_func) begin
            ram_we   = load_ok;
            ram_addr = load_addr;
            ram_wd   = i_cell_wall;
        end else begin
            ram_we   = 1'b0;
            ram_addr = pick_addr;
            ram_wd   = 1'b0;
        end
    end

    grc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wd),
        .o_rdata (ram_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            grc_pkg::S_CLEAR:  if (r_clr == AW'(DEPTH - 1)) n_state = grc_pkg::S_IDLE;
            grc_pkg::S_IDLE: begin
                if (accept && i_func) begin
                    n_state = (i_ray_angle[13:0] == '0) ? grc_pkg::S_SETUP
                                                        : grc_pkg::S_CORDIC;
                end
            end
            grc_pkg::S_CORDIC: begin
                if (r_i == 5'(grc_pkg::CORDIC_STEPS - 1)) n_state = grc_pkg::S_SETUP;
            end
            grc_pkg::S_SETUP:  n_state = (sxn0 || syn0) ? grc_pkg::S_DD : grc_pkg::S_DONE;
            grc_pkg::S_DD:     n_state = grc_pkg::S_MUL;
            grc_pkg::S_MUL:    n_state = grc_pkg::S_DIVD;
            grc_pkg::S_DIVD:   if (div_last) n_state = grc_pkg::S_DIVC;
            grc_pkg::S_DIVC: begin
                if (div_last) n_state = (r_both && !r_ax) ? grc_pkg::S_DD : grc_pkg::S_PICK;
            end
            grc_pkg::S_PICK:   n_state = off ? grc_pkg::S_DONE : grc_pkg::S_READ;
            grc_pkg::S_READ: begin
                if (ram_rd || (r_n == NW'(LIMIT - 1))) n_state = grc_pkg::S_DONE;
                else n_state = grc_pkg::S_DD;
            end
            grc_pkg::S_DONE:   n_state = grc_pkg::S_IDLE;
            default:           n_state = grc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grc_pkg::S_CLEAR;
            r_clr   <= '0;
            r_px    <= '0;
            r_py    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == grc_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we && (i_cfg_idx == 2'(grc_pkg::REG_PX))) r_px <= i_cfg_wdata;
            if (i_cfg_we && (i_cfg_idx == 2'(grc_pkg::REG_PY))) r_py <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            grc_pkg::S_IDLE: begin
                r_quad       <= i_ray_angle[15:14];
                r_i          <= '0;
                r_cx         <= (i_ray_angle[13:0] == '0) ? (XW'(1) <<< 30)
                                                          : XW'(grc_pkg::CORDIC_X0);
                r_cy         <= '0;
                r_cz         <= XW'(i_ray_angle[13:0]) <<< 16;
                r_n          <= '0;
                r_res_dist   <= 17'(grc_pkg::DIST_MAX);
                r_res_side   <= '0;
                r_res_tex    <= '0;
                r_res_status <= 1'b1;
            end
            grc_pkg::S_CORDIC: begin
                r_i <= r_i + 1'b1;
                if (!r_cz[XW-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_v;
                end
            end
            grc_pkg::S_SETUP: begin
                r_dx   <= dx0;
                r_dy   <= dy0;
                r_sxn  <= sxn0;
                r_syn  <= syn0;
                r_vx   <= CW'(r_px >> FRAC_BITS) + CW'(sxn0 && !dx0[XW-1]);
                r_hy   <= CW'(r_py >> FRAC_BITS) + CW'(syn0 && !dy0[XW-1]);
                r_ax   <= !sxn0;
                r_both <= sxn0 && syn0;
            end
            grc_pkg::S_DD: begin
                r_dd <= dd_n;
            end
            grc_pkg::S_MUL: begin
                r_prod <= r_dd * (r_ax ? r_dx : r_dy);
                r_nq   <= NUM_W'(dd_mag) << 30;
                r_rem  <= '0;
                r_div  <= r_ax ? dy_mag : dx_mag;
                r_cnt  <= '0;
            end
            grc_pkg::S_DIVD: begin
                r_cnt <= r_cnt + 1'b1;
                r_nq  <= nq_n;
                r_rem <= rem_n;
                if (div_last) begin
                    if (r_ax) r_hd <= nq_n;
                    else      r_vd <= nq_n;
                    r_nq  <= prod_mag;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            grc_pkg::S_DIVC: begin
                r_cnt <= r_cnt + 1'b1;
                r_nq  <= nq_n;
                r_rem <= rem_n;
                if (div_last) begin
                    if (r_ax) r_hx <= coord;
                    else      r_vy <= coord;
                    if (r_both && !r_ax) begin
                        r_ax   <= 1'b1;
                        r_both <= 1'b0;
                    end
                end
            end
            grc_pkg::S_PICK: begin
                r_vert      <= vert;
                r_cand_dist <= (dsel > NUM_W'(grc_pkg::DIST_MAX)) ? 17'(grc_pkg::DIST_MAX)
                                                                  : 17'(dsel);
                r_cand_tex  <= tex;
                r_cand_side <= vert ? (r_dx[XW-1] ? 2'd0 : 2'd2)
                                    : (r_dy[XW-1] ? 2'd1 : 2'd3);
            end
            grc_pkg::S_READ: begin
                if (ram_rd) begin
                    r_res_dist   <= r_cand_dist;
                    r_res_side   <= r_cand_side;
                    r_res_tex    <= r_cand_tex;
                    r_res_status <= 1'b0;
                end else begin
                    r_n <= r_n + 1'b1;
                    if (r_vert) begin
                        r_vx <= r_vx + (r_dx[XW-1] ? -CW'(1) : CW'(1));
                        r_ax <= 1'b0;
                    end else begin
                        r_hy <= r_hy + (r_dy[XW-1] ? -CW'(1) : CW'(1));
                        r_ax <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign busy           = r_state != grc_pkg::S_IDLE;
    assign o_done         = r_state == grc_pkg::S_DONE;
    assign o_hit_distance = r_res_dist;
    assign o_wall_side    = r_res_side;
    assign o_tex_coord    = r_res_tex;
    assign o_status       = r_res_status;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func) |=> busy)
        else $error("cast beat did not raise busy");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_hit_distance == 17'(grc_pkg::DIST_MAX)
                                  && o_wall_side == 2'd0 && o_tex_coord == 10'd0))
        else $error("miss result carries hit fields");

    a_no_write_in_cast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_state != grc_pkg::S_CLEAR) |-> !ram_we)
        else $error("map written during a cast");

endmodule

// ----- src/grc_ram.sv -----
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- test/grid_ray_wall_caster_unit_test.sv -----
`timescale 1ns / 100ps

module grid_ray_wall_caster_unit_test;

    localparam int MAP_W     = 64;
    localparam int MAP_H     = 64;
    localparam int FRAC_BITS = 10;
    localparam int WATCHDOG  = 60000;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CAST = 1'b1;
    localparam logic [1:0] REG_BAD = 2'd3;

    localparam longint ATAN_TAB [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        bit          is_cfg;
        logic        func;
        logic [15:0] angle;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        wall;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_op;

    typedef struct {
        logic [16:0] distance;
        logic [1:0]  side;
        logic [9:0]  tex;
        logic        status;
    } t_hit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [15:0] i_ray_angle = '0;
    logic [5:0]  i_cell_row = '0;
    logic [5:0]  i_cell_col = '0;
    logic        i_cell_wall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_done;
    logic [16:0] o_hit_distance;
    logic [1:0]  o_wall_side;
    logic [9:0]  o_tex_coord;
    logic        o_status;

    grid_ray_wall_caster_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_op  pending_ops[$];
    t_hit expected_hits[$];
    t_op  cur_op;
    bit   wall_shadow [MAP_W*MAP_H];
    logic [15:0] px_shadow, py_shadow;
    int   errors, n_casts, n_loads, n_hits, n_off, n_cfg;
    int   gap_left, settle_cnt, stall_cnt;
    bit   idle_on;

    function automatic bit probe_cell(longint row, longint col, output bit off);
        if (row < 0 || row >= MAP_H || col < 0 || col >= MAP_W) begin
            off = 1'b1;
            return 1'b0;
        end
        off = 1'b0;
        return wall_shadow[row*MAP_W + col];
    endfunction

    function automatic int axis_sign(longint d);
        longint m;
        m = d < 0 ? -d : d;
        if (m < grc_pkg::DIR_EPS) return 0;
        return d < 0 ? -1 : 1;
    endfunction

    function automatic t_hit predict_cast(logic [15:0] ang);
        t_hit   r;
        longint x, y, z, xs, ys, cs, sn, dx, dy, px, py, vx, hy;
        longint vy, hx, ddx, ddy, row, col, w, one;
        longint unsigned vd, hd;
        int     sx, sy;
        bit     off;
        one = 64'sd1 <<< FRAC_BITS;
        x = grc_pkg::CORDIC_X0;
        y = 0;
        z = longint'(ang[13:0]) * 65536;
        if (ang[13:0] == 0) begin
            x = 64'sd1 <<< 30;
        end else begin
            for (int i = 0; i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= ATAN_TAB[i];
                end else begin
                    x += ys; y -= xs; z += ATAN_TAB[i];
                end
            end
        end
        case (ang[15:14])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        dx = cs;
        dy = -sn;
        sx = axis_sign(dx);
        sy = axis_sign(dy);
        px = longint'(px_shadow);
        py = longint'(py_shadow);
        vx = (px >>> FRAC_BITS) + (sx > 0 ? 1 : 0);
        hy = (py >>> FRAC_BITS) + (sy > 0 ? 1 : 0);
        r = '{distance: 17'(grc_pkg::DIST_MAX), side: 2'd0, tex: 10'd0, status: 1'b1};
        for (int n = 0; n < MAP_W + MAP_H + 4; n++) begin
            vd = 0; hd = 0; vy = 0; hx = 0;
            if (sx != 0) begin
                ddx = vx*one - px;
                vy = py + ddx*dy/dx;
                vd = (longint'(ddx < 0 ? -ddx : ddx) << 30) / (dx < 0 ? -dx : dx);
            end
            if (sy != 0) begin
                ddy = hy*one - py;
                hx = px + ddy*dx/dy;
                hd = (longint'(ddy < 0 ? -ddy : ddy) << 30) / (dy < 0 ? -dy : dy);
            end
            if (sx != 0 && (sy == 0 || vd < hd)) begin
                row = vy >>> FRAC_BITS;
                col = vx + (sx > 0 ? 0 : -1);
                if (probe_cell(row, col, off)) begin
                    w = vy - row*one;
                    if (sx > 0) w = (w == 0) ? one - 1 : one - w;
                    r.distance = 17'(vd > grc_pkg::DIST_MAX ? grc_pkg::DIST_MAX : vd);
                    r.side = 2'(sx + 1);
                    r.tex = 10'(w);
                    r.status = 1'b0;
                    return r;
                end
                if (off) return r;
                vx += sx;
            end else if (sy != 0) begin
                row = hy + (sy > 0 ? 0 : -1);
                col = hx >>> FRAC_BITS;
                if (probe_cell(row, col, off)) begin
                    w = hx - col*one;
                    if (sy < 0) w = (w == 0) ? one - 1 : one - w;
                    r.distance = 17'(hd > grc_pkg::DIST_MAX ? grc_pkg::DIST_MAX : hd);
                    r.side = 2'(sy + 2);
                    r.tex = 10'(w);
                    r.status = 1'b0;
                    return r;
                end
                if (off) return r;
                hy += sy;
            end else begin
                return r;
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        bit n_start, n_we, took;
        t_hit h;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            n_start = start;
            n_we = 1'b0;
            took = 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == grc_pkg::REG_PX) px_shadow = i_cfg_wdata;
                else if (i_cfg_idx == grc_pkg::REG_PY) py_shadow = i_cfg_wdata;
            end
            if (start && !busy) begin
                took = 1'b1;
                n_start = 1'b0;
                if (cur_op.func == FUNC_LOAD) begin
                    wall_shadow[cur_op.row*MAP_W + cur_op.col] = cur_op.wall;
                    n_loads++;
                end else begin
                    h = predict_cast(cur_op.angle);
                    expected_hits.push_back(h);
                    n_casts++;
                    if (h.status) n_off++; else n_hits++;
                end
            end
            if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
            if (took && idle_on && pending_ops.size() > 80 && $urandom_range(0, 2) == 0)
                gap_left = $urandom_range(1, 19);
            if (!n_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0) begin
                    if (pending_ops[0].is_cfg) begin
                        if (expected_hits.size() == 0 && !busy && !start && !i_cfg_we)
                            settle_cnt++;
                        else
                            settle_cnt = 0;
                        if (settle_cnt >= 8) begin
                            n_we = 1'b1;
                            i_cfg_idx <= pending_ops[0].idx;
                            i_cfg_wdata <= pending_ops[0].data;
                            void'(pending_ops.pop_front());
                            settle_cnt = 0;
                            n_cfg++;
                        end
                    end else begin
                        cur_op = pending_ops.pop_front();
                        n_start = 1'b1;
                        i_func <= cur_op.func;
                        i_ray_angle <= cur_op.angle;
                        i_cell_row <= cur_op.row;
                        i_cell_col <= cur_op.col;
                        i_cell_wall <= cur_op.wall;
                    end
                end
            end
            start <= n_start;
            i_cfg_we <= n_we;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_hit e;
        if (i_rst_n && o_done) begin
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: dist %0d side %0d",
                                           o_hit_distance, o_wall_side);
            end else begin
                e = expected_hits.pop_front();
                if (o_hit_distance !== e.distance || o_wall_side !== e.side ||
                    o_tex_coord !== e.tex || o_status !== e.status) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp d=%0d s=%0d t=%0d st=%0d,",
                                  " got d=%0d s=%0d t=%0d st=%0d"},
                                 e.distance, e.side, e.tex, e.status, o_hit_distance,
                                 o_wall_side, o_tex_coord, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done || i_cfg_we) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= WATCHDOG) begin
                $display("grid_ray_wall_caster_unit_test: done, errors");
                $finish;
            end
        end
    end

    task automatic add_cfg(logic [1:0] idx, logic [15:0] data);
        t_op o;
        o = '{default: '0};
        o.is_cfg = 1'b1; o.idx = idx; o.data = data;
        pending_ops.push_back(o);
    endtask

    task automatic add_load(logic [5:0] row, logic [5:0] col, logic wall);
        t_op o;
        o = '{default: '0};
        o.func = FUNC_LOAD; o.row = row; o.col = col; o.wall = wall;
        o.angle = 16'($urandom);
        pending_ops.push_back(o);
    endtask

    task automatic add_cast(logic [15:0] ang);
        t_op o;
        o = '{default: '0};
        o.func = FUNC_CAST; o.angle = ang;
        o.row = 6'($urandom); o.col = 6'($urandom); o.wall = 1'($urandom);
        pending_ops.push_back(o);
    endtask

    initial begin
        int items, cx, cy;
        logic [15:0] a;
        foreach (wall_shadow[i]) wall_shadow[i] = 1'b0;
        px_shadow = '0; py_shadow = '0;
        errors = 0; n_casts = 0; n_loads = 0; n_hits = 0; n_off = 0; n_cfg = 0;
        gap_left = 0; settle_cnt = 0; stall_cnt = 0; idle_on = 1'b0;
        items = 0;

        // directed: player at origin corner, empty map, axis rays, bad register
        add_cfg(2'(grc_pkg::REG_PX), 16'd0);
        add_cfg(2'(grc_pkg::REG_PY), 16'd0);
        add_cfg(REG_BAD, 16'hFFFF);
        add_cast(16'd0);
        add_cast(16'd49152);
        add_cast(16'd16384);
        add_load(6'd0, 6'd0, 1'b1);
        add_load(6'd63, 6'd63, 1'b1);
        add_load(6'd63, 6'd63, 1'b0);
        add_cfg(2'(grc_pkg::REG_PX), 16'(32*1024 + 512));
        add_cfg(2'(grc_pkg::REG_PY), 16'(32*1024 + 512));
        add_load(6'd32, 6'd36, 1'b1);
        add_load(6'd28, 6'd32, 1'b1);
        add_load(6'd32, 6'd29, 1'b1);
        add_load(6'd35, 6'd32, 1'b1);
        add_load(6'd35, 6'd35, 1'b1);
        add_cast(16'd0);
        add_cast(16'd16384);
        add_cast(16'd32768);
        add_cast(16'd49152);
        add_cast(16'd1);
        add_cast(16'd16383);
        add_cast(16'd65535);
        add_cast(16'd57344);
        add_cast(16'd8192);
        add_cfg(2'(grc_pkg::REG_PX), 16'hFFFF);
        add_cfg(2'(grc_pkg::REG_PY), 16'hFFFF);
        add_cast(16'd0);
        add_cast(16'd8192);
        items = 22;

        while (items < 1150) begin
            case ($urandom_range(0, 5))
                0: begin cx = 0; cy = 65535; end
                1: begin cx = 65535; cy = $urandom_range(0, 65535); end
                2: begin cx = $urandom_range(0, 65535); cy = $urandom_range(0, 65535); end
                default: begin
                    cx = $urandom_range(20*1024, 44*1024);
                    cy = $urandom_range(20*1024, 44*1024);
                end
            endcase
            add_cfg(2'(grc_pkg::REG_PX), 16'(cx));
            add_cfg(2'(grc_pkg::REG_PY), 16'(cy));
            for (int i = 0; i < 14; i++) begin
                if ($urandom_range(0, 4) == 0)
                    add_load(6'($urandom), 6'($urandom), 1'($urandom));
                else
                    add_load(6'(((cy >> 10) + $urandom_range(0, 12) - 6) & 63),
                             6'(((cx >> 10) + $urandom_range(0, 12) - 6) & 63),
                             $urandom_range(0, 9) < 7);
                items++;
            end
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 5) == 0)
                    a = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
                else
                    a = 16'($urandom);
                add_cast(a);
                items++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        while (start || busy || expected_hits.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("casts %0d (wall hits %0d, off map %0d), cell loads %0d, register writes %0d",
                 n_casts, n_hits, n_off, n_loads, n_cfg);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("grid_ray_wall_caster_unit_test: done, clean");
        end else begin
            $display("mismatches %0d, results still owed %0d", errors, expected_hits.size());
            $display("grid_ray_wall_caster_unit_test: done, errors");
        end
        $finish;
    end

endmodule
